// File: rtl/rsk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsk_pkg
// Shared types, register map and constants of the RMS soft-knee compressor.
// ----------------------------------------------------------------------------
package rsk_pkg;

  // datapath operations, one per controller state
  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_POWL, OP_POWR, OP_ENVC, OP_ENVM1, OP_ENVM2, OP_ENVS,
    OP_NORM, OP_LOG, OP_LVLM, OP_LVLS, OP_GCMP, OP_GSQ, OP_DIV, OP_GRM,
    OP_GRS, OP_GEXP, OP_GINT, OP_GMK, OP_GMR, OP_APL, OP_APR, OP_PUB
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] step;
  } cmd_t;

  typedef struct packed {
    logic env_zero;
    logic in_knee;
  } sts_t;

  typedef struct packed {
    logic [23:0]        atk_coeff;
    logic [23:0]        rel_coeff;
    logic signed [15:0] threshold;
    logic [12:0]        knee;
    logic [15:0]        slope;
    logic [15:0]        makeup;
    logic [1:0]         chan;
  } cfg_t;

  // register indexes
  localparam logic [2:0] REG_ATTACK    = 3'd0;
  localparam logic [2:0] REG_RELEASE   = 3'd1;
  localparam logic [2:0] REG_THRESHOLD = 3'd2;
  localparam logic [2:0] REG_KNEE      = 3'd3;
  localparam logic [2:0] REG_SLOPE     = 3'd4;
  localparam logic [2:0] REG_MAKEUP    = 3'd5;
  localparam logic [2:0] REG_CHANNELS  = 3'd6;

  localparam logic [23:0] RST_ATTACK    = 24'd16400000;
  localparam logic [23:0] RST_RELEASE   = 24'd16700000;
  localparam logic [15:0] RST_THRESHOLD = 16'hEE00;   // -18 dB
  localparam logic [12:0] RST_KNEE      = 13'd1536;
  localparam logic [15:0] RST_SLOPE     = 16'd0;
  localparam logic [15:0] RST_MAKEUP    = 16'd16384;
  localparam logic [1:0]  RST_CHANNELS  = 2'd2;
  localparam logic [1:0]  CHAN_MONO     = 2'd1;

  localparam logic signed [16:0] LVL_FLOOR = -17'sd25600;  // -100 dB
  localparam logic [17:0] LOG_SCALE  = 18'd197283;  // 10*log10(2), Q.16
  localparam logic [13:0] OCT_SCALE  = 14'd10885;   // dB to octaves
  localparam logic [14:0] GR_MAX     = 15'd32767;
  localparam logic [4:0]  NORM_LAST  = 5'd4;
  localparam logic [4:0]  LOG_LAST   = 5'd15;
  localparam logic [4:0]  DIV_LAST   = 5'd25;

  // 2^-(i/16), Q1.16
  function automatic logic [16:0] exp_val(input logic [4:0] idx);
    logic [16:0] v;
    case (idx)
      5'd0:  v = 17'd65536;
      5'd1:  v = 17'd62757;
      5'd2:  v = 17'd60097;
      5'd3:  v = 17'd57549;
      5'd4:  v = 17'd55109;
      5'd5:  v = 17'd52773;
      5'd6:  v = 17'd50535;
      5'd7:  v = 17'd48393;
      5'd8:  v = 17'd46341;
      5'd9:  v = 17'd44376;
      5'd10: v = 17'd42495;
      5'd11: v = 17'd40693;
      5'd12: v = 17'd38968;
      5'd13: v = 17'd37316;
      5'd14: v = 17'd35734;
      5'd15: v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/rms_soft_knee_compressor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_soft_knee_compressor
// Feed-forward RMS compressor with soft knee, one stereo frame per transaction.
// ----------------------------------------------------------------------------
// One frame is in flight at a time. The 26-step restoring divider of the
// knee curve runs only when the level lies inside the knee. A frame with an
// empty envelope skips the 5-step normalize and the 16-step log2 squaring
// loop. The finished result sits in an output register, so the next frame
// is accepted while the previous one waits to be taken. Registers must be
// written over the APB port only while the block is idle; the user must keep
// to this, as the block itself does not enforce it.
module rms_soft_knee_compressor #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // in_left, in_right
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // out_left, out_right, reduction_level
  output logic [((2*SAMPLE_BITS+22)/8)*8-1:0]   m_tdata,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [4:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import rsk_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int MW = ((2*SB+22)/8)*8;

  cfg_t  cfg;
  cmd_t  cmd;
  sts_t  sts;
  logic  wr;
  logic signed [SB-1:0] out_l, out_r;
  logic [14:0]          out_gr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.atk_coeff <= RST_ATTACK;
      cfg.rel_coeff <= RST_RELEASE;
      cfg.threshold <= $signed(RST_THRESHOLD);
      cfg.knee      <= RST_KNEE;
      cfg.slope     <= RST_SLOPE;
      cfg.makeup    <= RST_MAKEUP;
      cfg.chan      <= RST_CHANNELS;
    end else if (wr) begin
      case (paddr[4:2])
        REG_ATTACK:    cfg.atk_coeff <= pwdata[23:0];
        REG_RELEASE:   cfg.rel_coeff <= pwdata[23:0];
        REG_THRESHOLD: cfg.threshold <= $signed(pwdata[15:0]);
        REG_KNEE:      cfg.knee      <= pwdata[12:0];
        REG_SLOPE:     cfg.slope     <= pwdata[15:0];
        REG_MAKEUP:    cfg.makeup    <= pwdata[15:0];
        REG_CHANNELS:  cfg.chan      <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_ATTACK:    prdata = 32'(cfg.atk_coeff);
      REG_RELEASE:   prdata = 32'(cfg.rel_coeff);
      REG_THRESHOLD: prdata = 32'($unsigned(cfg.threshold));
      REG_KNEE:      prdata = 32'(cfg.knee);
      REG_SLOPE:     prdata = 32'(cfg.slope);
      REG_MAKEUP:    prdata = 32'(cfg.makeup);
      REG_CHANNELS:  prdata = 32'(cfg.chan);
      default:       prdata = '0;
    endcase
  end

  rsk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rsk_dp #(.SB(SB)) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .cfg    (cfg),
    .in_l   ($signed(s_tdata[SB-1:0])),
    .in_r   ($signed(s_tdata[2*SB-1:SB])),
    .sts    (sts),
    .out_l  (out_l),
    .out_r  (out_r),
    .out_gr (out_gr)
  );

  assign m_tdata = MW'({out_gr, out_r, out_l});

endmodule

// File: rtl/rsk_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsk_ctrl
// Sequencer: walks one frame through the datapath and owns the handshakes.
// ----------------------------------------------------------------------------
module rsk_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  input  rsk_pkg::sts_t sts,
  output rsk_pkg::cmd_t cmd
);
  import rsk_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_POWL, S_POWR, S_ENVC, S_ENVM1, S_ENVM2, S_ENVS, S_NORM, S_LOG,
    S_LVLM, S_LVLS, S_GCMP, S_GSQ, S_DIV, S_GRM, S_GRS, S_GEXP, S_GINT,
    S_GMK, S_GMR, S_APL, S_APR, S_PUB
  } state_t;

  state_t     state;
  logic [4:0] cnt;
  logic       pub_ok;

  assign s_tready = (state == S_IDLE);
  assign pub_ok   = !m_tvalid || m_tready;

  always_comb begin
    cmd.step = cnt[2:0];
    case (state)
      S_IDLE:  cmd.op = s_tvalid ? OP_LOAD : OP_NOP;
      S_POWL:  cmd.op = OP_POWL;
      S_POWR:  cmd.op = OP_POWR;
      S_ENVC:  cmd.op = OP_ENVC;
      S_ENVM1: cmd.op = OP_ENVM1;
      S_ENVM2: cmd.op = OP_ENVM2;
      S_ENVS:  cmd.op = OP_ENVS;
      S_NORM:  cmd.op = OP_NORM;
      S_LOG:   cmd.op = OP_LOG;
      S_LVLM:  cmd.op = OP_LVLM;
      S_LVLS:  cmd.op = OP_LVLS;
      S_GCMP:  cmd.op = OP_GCMP;
      S_GSQ:   cmd.op = OP_GSQ;
      S_DIV:   cmd.op = OP_DIV;
      S_GRM:   cmd.op = OP_GRM;
      S_GRS:   cmd.op = OP_GRS;
      S_GEXP:  cmd.op = OP_GEXP;
      S_GINT:  cmd.op = OP_GINT;
      S_GMK:   cmd.op = OP_GMK;
      S_GMR:   cmd.op = OP_GMR;
      S_APL:   cmd.op = OP_APL;
      S_APR:   cmd.op = OP_APR;
      S_PUB:   cmd.op = pub_ok ? OP_PUB : OP_NOP;
      default: cmd.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == S_PUB && pub_ok) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE:  if (s_tvalid) state <= S_POWL;
        S_POWL:  state <= S_POWR;
        S_POWR:  state <= S_ENVC;
        S_ENVC:  state <= S_ENVM1;
        S_ENVM1: state <= S_ENVM2;
        S_ENVM2: state <= S_ENVS;
        S_ENVS: begin
          state <= S_NORM;
          cnt   <= '0;
        end
        S_NORM: begin
          // empty envelope takes the floor level, no log needed
          if (sts.env_zero) begin
            state <= S_LVLM;
          end else if (cnt == NORM_LAST) begin
            state <= S_LOG;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_LOG: begin
          if (cnt == LOG_LAST) state <= S_LVLM;
          else cnt <= cnt + 5'd1;
        end
        S_LVLM:  state <= S_LVLS;
        S_LVLS:  state <= S_GCMP;
        S_GCMP:  state <= S_GSQ;
        S_GSQ: begin
          cnt   <= '0;
          state <= sts.in_knee ? S_DIV : S_GRM;
        end
        S_DIV: begin
          if (cnt == DIV_LAST) state <= S_GRM;
          else cnt <= cnt + 5'd1;
        end
        S_GRM:   state <= S_GRS;
        S_GRS:   state <= S_GEXP;
        S_GEXP:  state <= S_GINT;
        S_GINT:  state <= S_GMK;
        S_GMK:   state <= S_GMR;
        S_GMR:   state <= S_APL;
        S_APL:   state <= S_APR;
        S_APR:   state <= S_PUB;
        S_PUB: begin
          if (pub_ok) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/rsk_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsk_dp
// Datapath: power, envelope filter, log level, knee, gain and output scaling.
// ----------------------------------------------------------------------------
module rsk_dp #(
  parameter int SB = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rsk_pkg::cmd_t        cmd,
  input  rsk_pkg::cfg_t        cfg,
  input  logic signed [SB-1:0] in_l,
  input  logic signed [SB-1:0] in_r,
  output rsk_pkg::sts_t        sts,
  output logic signed [SB-1:0] out_l,
  output logic signed [SB-1:0] out_r,
  output logic [14:0]          out_gr
);
  import rsk_pkg::*;

  localparam int PSH = 2 * (SB - 1) - 32;
  localparam int SHR = (PSH >= 0) ? PSH : 0;
  localparam int SHL = (PSH < 0) ? -PSH : 0;
  localparam int PW  = 2 * SB + 32;
  localparam int AW  = SB + 19;
  localparam logic [SB+2:0] VHI = (SB+3)'((64'd1 << (SB - 1)) - 64'd1);
  localparam logic [SB+2:0] VLO = (SB+3)'(64'd1 << (SB - 1));

  // x*x to Q0.32, saturated
  function automatic logic [31:0] power_of(input logic signed [SB-1:0] x);
    logic [SB-1:0]   mag;
    logic [2*SB-1:0] sq;
    logic [PW-1:0]   pw;
    mag = x[SB-1] ? $unsigned(-x) : $unsigned(x);
    sq  = (2*SB)'(mag) * (2*SB)'(mag);
    pw  = (PW'(sq) << SHL) >> SHR;
    return (|pw[PW-1:32]) ? 32'hFFFF_FFFF : pw[31:0];
  endfunction

  // x*gm/2^16, rounded half away from zero, saturated
  function automatic logic signed [SB-1:0] apply(input logic signed [SB-1:0] x,
                                                 input logic [18:0] g);
    logic [SB-1:0]   mag;
    logic [AW-1:0]   prod;
    logic [SB+2:0]   v;
    logic [SB-1:0]   r;
    mag  = x[SB-1] ? $unsigned(-x) : $unsigned(x);
    prod = AW'(mag) * AW'(g);
    v    = (SB+3)'((prod + AW'(32768)) >> 16);
    if (!x[SB-1]) r = (v > VHI) ? VHI[SB-1:0] : v[SB-1:0];
    else if (v > VLO) r = VLO[SB-1:0];
    else r = ~v[SB-1:0] + SB'(1);
    return $signed(r);
  endfunction

  logic signed [SB-1:0] xl, xr, yl, yr;
  logic                 mono;
  logic [31:0]          p, env, mant;
  logic [23:0]          coef;
  logic [55:0]          m1;
  logic [56:0]          m2;
  logic [4:0]           lz;
  logic [15:0]          frac;
  logic [39:0]          lprod;
  logic signed [16:0]   lvl;
  logic                 below, above;
  logic [12:0]          xk;
  logic [16:0]          dpos;
  logic [25:0]          num, quo;
  logic [13:0]          rem;
  logic [41:0]          grp;
  logic [14:0]          gr;
  logic [20:0]          tq;
  logic [16:0]          gi;
  logic [32:0]          gmp;
  logic [18:0]          gm;

  // combinational helpers
  logic [31:0]        pwr, env_next;
  logic [4:0]         amt;
  logic [63:0]        sq;
  logic [32:0]        sqs;
  logic [21:0]        lneg;
  logic [15:0]        lr;
  logic signed [17:0] t18, l18, lo18, hi18, h18;
  logic [14:0]        dr, dd;
  logic [25:0]        sel;
  logic [41:0]        grv;
  logic [4:0]         ei;
  logic [16:0]        e0, e1;
  logic [28:0]        itp;
  logic [16:0]        gs;
  logic [24:0]        omc;

  always_comb begin
    pwr      = power_of(xr);
    omc      = 25'h100_0000 - {1'b0, coef};
    env_next = 32'((58'(m1) + 58'(m2) + 58'h80_0000) >> 24);
    case (cmd.step)
      3'd0:    amt = 5'd16;
      3'd1:    amt = 5'd8;
      3'd2:    amt = 5'd4;
      3'd3:    amt = 5'd2;
      default: amt = 5'd1;
    endcase
    sq   = 64'(mant) * 64'(mant);
    sqs  = sq[63:31];
    lneg = ((22'(lz) + 22'd1) << 16) - 22'(frac);
    lr   = 16'((lprod + 40'h80_0000) >> 24);
    t18  = 18'(cfg.threshold);
    h18  = $signed({6'd0, cfg.knee[12:1]});
    l18  = 18'(lvl);
    lo18 = t18 - h18;
    hi18 = t18 + h18;
    dr   = {rem, num[25]};
    dd   = {1'b0, cfg.knee, 1'b0};
    sel  = above ? 26'(dpos) : ((cfg.knee == '0) ? '0 : quo);
    grv  = (grp + 42'd32768) >> 16;
    ei   = {1'b0, tq[15:12]};
    e0   = exp_val(ei);
    e1   = exp_val(ei + 5'd1);
    itp  = (29'(e0 - e1) * 29'(tq[11:0]) + 29'd2048) >> 12;
    gs   = (tq[20:16] == 5'd31) ? '0 : (gi >> tq[20:16]);
  end

  assign sts.env_zero = (env == '0);
  assign sts.in_knee  = !below && !above;

  always_ff @(posedge clk) begin
    if (rst) begin
      env <= '0;
    end else if (cmd.op == OP_ENVS) begin
      env <= env_next;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        xl   <= in_l;
        xr   <= in_r;
        mono <= (cfg.chan == CHAN_MONO);
      end
      OP_POWL:  p <= power_of(xl);
      OP_POWR:  if (!mono) p <= 32'((33'(p) + 33'(pwr)) >> 1);
      OP_ENVC:  coef <= (p > env) ? cfg.atk_coeff : cfg.rel_coeff;
      OP_ENVM1: m1 <= 56'(coef) * 56'(env);
      OP_ENVM2: m2 <= 57'(omc) * 57'(p);
      OP_ENVS: begin
        mant <= env_next;
        lz   <= '0;
        frac <= '0;
      end
      OP_NORM: begin
        // binary-search normalize: shift out leading zeros in halving chunks
        if ((mant >> (6'd32 - {1'b0, amt})) == '0) begin
          mant <= mant << amt;
          lz   <= lz + amt;
        end
      end
      OP_LOG: begin
        // one fraction bit of log2 per squaring
        frac <= {frac[14:0], sqs[32]};
        mant <= sqs[32] ? sqs[32:1] : sqs[31:0];
      end
      OP_LVLM: lprod <= 40'(lneg) * 40'(LOG_SCALE);
      OP_LVLS: lvl <= sts.env_zero ? LVL_FLOOR : -$signed({1'b0, lr});
      OP_GCMP: begin
        below <= (l18 <= lo18);
        above <= (l18 >= hi18);
        xk    <= 13'(l18 - lo18);
        dpos  <= 17'(l18 - t18);
      end
      OP_GSQ: begin
        num <= 26'(xk) * 26'(xk);
        rem <= '0;
        quo <= '0;
      end
      OP_DIV: begin
        num <= num << 1;
        if (dr >= dd) begin
          rem <= 14'(dr - dd);
          quo <= {quo[24:0], 1'b1};
        end else begin
          rem <= dr[13:0];
          quo <= {quo[24:0], 1'b0};
        end
      end
      OP_GRM:  grp <= 42'(sel) * 42'(cfg.slope);
      OP_GRS: begin
        if (below) gr <= '0;
        else if (grv > 42'(GR_MAX)) gr <= GR_MAX;
        else gr <= grv[14:0];
      end
      OP_GEXP: tq <= 21'((30'(gr) * 30'(OCT_SCALE) + 30'd128) >> 8);
      OP_GINT: gi <= e0 - 17'(itp);
      OP_GMK:  gmp <= 33'(gs) * 33'(cfg.makeup);
      OP_GMR:  gm <= 19'((34'(gmp) + 34'd8192) >> 14);
      OP_APL:  yl <= apply(xl, gm);
      OP_APR:  yr <= mono ? '0 : apply(xr, gm);
      OP_PUB: begin
        out_l  <= yl;
        out_r  <= yr;
        out_gr <= gr;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/rsk_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsk_checker
// Port-level checks of the compressor's stream behavior.
// ----------------------------------------------------------------------------
module rsk_checker #(
  parameter int MW = 64
) (
  input logic          clk,
  input logic          rst,
  input logic          s_tvalid,
  input logic          s_tready,
  input logic          m_tvalid,
  input logic          m_tready,
  input logic [MW-1:0] m_tdata
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // one frame in flight: input closes right after a transaction
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input open while frame in flight");

  // a result never shows up the cycle after its frame was taken
  a_lat: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
    else $error("result too early");

endmodule

bind rms_soft_knee_compressor rsk_checker #(.MW(MW)) u_chk (.*);

// File: tb/sv/rms_soft_knee_compressor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_soft_knee_compressor_tb
// Drives stereo frames and register writes into the compressor, predicts
// every output frame with a bit-exact fixed-point model of the envelope,
// log level, soft-knee gain computer and gain stage, and checks each one.
// ----------------------------------------------------------------------------
module rms_soft_knee_compressor_tb;
  import rsk_pkg::*;

  localparam int SW = 24;
  localparam longint CYCLE_LIMIT = 2000000;

  class gain_scoreboard;
    logic [23:0] atk, rel, slope, makeup;
    logic [15:0] thr;
    logic [12:0] knee;
    logic [1:0]  chan;
    logic [31:0] env;
    logic [63:0] pending_frames[$];
    int          errors;

    function void reset_state();
      atk = RST_ATTACK; rel = RST_RELEASE; thr = RST_THRESHOLD; knee = RST_KNEE;
      slope = RST_SLOPE; makeup = RST_MAKEUP; chan = RST_CHANNELS; env = 0;
      pending_frames.delete();
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_ATTACK:    atk = v[23:0];
        REG_RELEASE:   rel = v[23:0];
        REG_THRESHOLD: thr = v[15:0];
        REG_KNEE:      knee = v[12:0];
        REG_SLOPE:     slope = v[15:0];
        REG_MAKEUP:    makeup = v[15:0];
        REG_CHANNELS:  chan = v[1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned sample_power(longint x);
      longint unsigned m, sq;
      m = x < 0 ? -x : x;
      sq = (m * m) >> (2 * (SW - 1) - 32);
      return sq > 64'hFFFFFFFF ? 64'hFFFFFFFF : sq;
    endfunction

    function longint level_q8(logic [31:0] e);
      int msb;
      longint unsigned mant, prod;
      longint frac, neg;
      if (e == 0) return -25600;
      msb = 31;
      while (!e[msb]) msb--;
      mant = 64'(e) << (31 - msb);
      frac = 0;
      for (int i = 0; i < 16; i++) begin
        mant = (mant * mant) >> 31;
        frac = frac << 1;
        if (mant >= 64'h1_0000_0000) begin
          frac = frac | 1;
          mant = mant >> 1;
        end
      end
      neg = longint'(32 - msb) * 65536 - frac;
      prod = (64'(neg) * 197283 + (64'd1 << 23)) >> 24;
      return -longint'(prod);
    endfunction

    function longint reduction_q8(longint lvl);
      longint t, k, h, gr, x, q;
      t = longint'($signed(thr));
      k = knee;
      h = k >>> 1;
      if (lvl <= t - h) return 0;
      if (lvl >= t + h) gr = ((lvl - t) * longint'(slope) + 32768) >>> 16;
      else begin
        x = lvl - (t - h);
        q = k > 0 ? (x * x) / (2 * k) : 0;
        gr = (q * longint'(slope) + 32768) >>> 16;
      end
      return gr > 32767 ? 32767 : gr;
    endfunction

    function longint unsigned gain_q16(longint gr);
      longint unsigned t, n, f, g, a, b;
      int idx;
      t = (64'(gr) * 10885 + 128) >> 8;
      n = t >> 16;
      f = t & 16'hFFFF;
      idx = int'(f >> 12);
      a = exp_val(5'(idx));
      b = exp_val(5'(idx + 1));
      g = a - (((a - b) * (f & 12'hFFF) + 2048) >> 12);
      g = n >= 31 ? 0 : (g >> n);
      return (g * makeup + 8192) >> 14;
    endfunction

    function logic [23:0] scale_sample(longint x, longint unsigned gm);
      longint unsigned m;
      longint v;
      m = x < 0 ? -x : x;
      v = longint'((m * gm + 32768) >> 16);
      if (x < 0) v = -v;
      if (v > 8388607) v = 8388607;
      if (v < -8388608) v = -8388608;
      return v[23:0];
    endfunction

    function void note_frame(logic [47:0] d);
      longint xl, xr, gr;
      longint unsigned p, c, gm;
      logic mono;
      xl = longint'($signed(d[23:0]));
      xr = longint'($signed(d[47:24]));
      mono = chan == CHAN_MONO;
      p = sample_power(xl);
      if (!mono) p = (p + sample_power(xr)) >> 1;
      c = p > env ? atk : rel;
      env = 32'((c * env + (64'd16777216 - c) * p + 64'd8388608) >> 24);
      gr = reduction_q8(level_q8(env));
      gm = gain_q16(gr);
      pending_frames.push_back({1'b0, gr[14:0], mono ? 24'd0 : scale_sample(xr, gm),
                                scale_sample(xl, gm)});
    endfunction

    function void report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endfunction

    function void check_frame(logic [63:0] d);
      logic [63:0] e;
      if (pending_frames.size() == 0) begin
        report("unexpected frame", d, 0);
        return;
      end
      e = pending_frames.pop_front();
      if (d[23:0] !== e[23:0]) report("out_left", d[23:0], e[23:0]);
      if (d[47:24] !== e[47:24]) report("out_right", d[47:24], e[47:24]);
      if (d[62:48] !== e[62:48]) report("reduction_level", d[62:48], e[62:48]);
    endfunction
  endclass

  logic        clk, rst;
  logic        s_tvalid, s_tready, m_tvalid, m_tready;
  logic [47:0] s_tdata;
  logic [63:0] m_tdata;
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;

  gain_scoreboard sb;
  int  send_idle_pct, recv_idle_pct;
  bit  hold_off;
  longint cycles;

  rms_soft_knee_compressor dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("rms_soft_knee_compressor test failed");
      $finish;
    end
  end

  // receiver side: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    if (!rst && m_tvalid && m_tready) sb.check_frame(m_tdata);
  end

  // tvalid stays up after a transaction; a pause in the next call, wait_drain or write_reg drops it
  task automatic send_frame(logic [23:0] l, logic [23:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {r, l};
    do @(posedge clk); while (!s_tready);
    sb.note_frame({r, l});
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (sb.pending_frames.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    s_tvalid <= 1'b0;
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= v; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, v);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(2000)) - 1000);
      2: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      default: return 24'($signed(24'($urandom)) >>> $urandom_range(12));
    endcase
  endfunction

  task automatic random_config(bit extreme);
    write_reg(REG_ATTACK, extreme ? ($urandom_range(1) ? 0 : 24'hFFFFFF)
                                  : $urandom_range(16777215, 14000000));
    write_reg(REG_RELEASE, extreme ? ($urandom_range(1) ? 0 : 24'hFFFFFF)
                                   : $urandom_range(16777215, 14000000));
    write_reg(REG_THRESHOLD, extreme ? ($urandom_range(1) ? 32'hFFFF9C00 : 0)
                                     : 32'(-$signed($urandom_range(12000))));
    write_reg(REG_KNEE, $urandom_range(3) == 0 ? $urandom_range(1) * 6144
                                               : $urandom_range(6144));
    write_reg(REG_SLOPE, extreme ? ($urandom_range(1) ? 65535 : 0) : $urandom_range(65535));
    write_reg(REG_MAKEUP, extreme ? ($urandom_range(1) ? 65535 : 0)
                                  : $urandom_range(40000, 8000));
    write_reg(REG_CHANNELS, $urandom_range(3));
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    cycles = 0; hold_off = 0;
    rst = 1; s_tvalid = 0; s_tdata = 0; m_tready = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    send_idle_pct = 23; recv_idle_pct = 77;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: default config first, then hard knee, odd knee, mono, wide writes
    send_frame(0, 0);
    send_frame(24'h7FFFFF, 24'h800000);
    send_frame(24'h800000, 24'h7FFFFF);
    send_frame(24'h000001, 24'hFFFFFF);
    wait_drain();
    write_reg(REG_SLOPE, 65535);
    write_reg(REG_KNEE, 0);
    write_reg(REG_ATTACK, 0);
    write_reg(REG_RELEASE, 24'hFFFFFF);
    write_reg(REG_MAKEUP, 65535);
    write_reg(REG_THRESHOLD, 32'hFFFF9C00);
    send_frame(24'h7FFFFF, 24'h7FFFFF);
    send_frame(24'h400000, 24'hC00000);
    send_frame(0, 0);
    wait_drain();
    write_reg(REG_KNEE, 32'hFFFF_E001);  // odd knee, upper bits dropped
    write_reg(REG_THRESHOLD, 32'h1234_F000);
    write_reg(REG_CHANNELS, 32'hFFFF_FFFD);  // mono via wide value
    write_reg(REG_MAKEUP, 0);
    send_frame(24'h7FFFFF, 24'h555555);
    wait_drain();
    write_reg(REG_MAKEUP, 16384);
    send_frame(24'h200000, 24'hAAAAAA);
    wait_drain();
    write_reg(REG_CHANNELS, 0);
    write_reg(REG_ATTACK, 24'hFFFFFF);
    write_reg(REG_RELEASE, 0);
    send_frame(24'h123456, 24'hEDCBA9);
    send_frame(24'h800000, 24'h800000);
    wait_drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = phase == 0 ? 23 : (phase == 1 ? 77 : 0);
      recv_idle_pct = phase == 0 ? 77 : (phase == 1 ? 23 : 0);
      for (int blk = 0; blk < 5; blk++) begin
        random_config(blk == 0);
        for (int i = 0; i < 60; i++) begin
          if (phase == 2 && blk == 1 && i == 10) begin
            hold_off = 1;
            fork
              begin repeat (400) @(posedge clk); hold_off = 0; end
            join_none
          end
          send_frame(rand_sample(), rand_sample());
        end
        wait_drain();
      end
    end

    wait_drain();
    if (sb.errors == 0 && sb.pending_frames.size() == 0)
      $display("rms_soft_knee_compressor test passed");
    else
      $display("rms_soft_knee_compressor test failed");
    $finish;
  end
endmodule
